FILE: rtl/rlwp_pkg.sv
// Package for the RGB level to WS2812 pulse encoder.
// Holds scaling constants, the shared level type and the pulse coding function.
// No dependencies.
package rlwp_pkg;

    localparam int unsigned ColorWidth = 8;
    localparam int unsigned PulseWidth = 3 * ColorWidth;

    localparam logic [7:0]  LevelHalf  = 8'd127;
    // floor(x / 255) == (x * 0x8081) >> 23 for every 16-bit x
    localparam logic [15:0] RecipMul   = 16'h8081;
    localparam int unsigned RecipShift = 23;

    localparam logic [2:0]  PulseOne   = 3'b110;
    localparam logic [2:0]  PulseZero  = 3'b100;

    typedef struct packed {
        logic [7:0] level;      // brightness * brightness / 255
        logic       bright_nz;  // brightness register is nonzero
    } t_level;

    function automatic logic [23:0] encode_pulses(input logic [7:0] value);
        logic [23:0] word;
        word = '0;
        for (int k = 0; k < 8; k++) begin
            word[3*k +: 3] = value[k] ? PulseOne : PulseZero;
        end
        return word;
    endfunction

endpackage

FILE: rtl/rlwp_ifs.sv
// Handshake channel interfaces: pixel input, pulse output and brightness write.
// No dependencies.
interface rlwp_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_value;
    logic [7:0] green_value;
    logic [7:0] blue_value;
    modport source (output valid, output red_value, output green_value,
                    output blue_value, input ready);
    modport sink   (input valid, input red_value, input green_value,
                    input blue_value, output ready);
endinterface

interface rlwp_pulse_if;
    logic        valid;
    logic        ready;
    logic [23:0] green_pulses;
    logic [23:0] red_pulses;
    logic [23:0] blue_pulses;
    modport source (output valid, output green_pulses, output red_pulses,
                    output blue_pulses, input ready);
    modport sink   (input valid, input green_pulses, input red_pulses,
                    input blue_pulses, output ready);
endinterface

interface rlwp_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/rgb_level_to_ws2812_pulses.sv
// RGB level to WS2812 pulse encoder, top level.
// Depends on rlwp_pkg, rlwp_ifs, rlwp_cfg, rlwp_lane and rlwp_merge.
//
// Usage:
//   i_pix   takes one LED color (red, green, blue bytes) per transfer.
//   o_pulse gives one result per pixel: three 24-bit pulse words, green,
//           red and blue, first transmitted pulse bit at bit 23.
//   i_cfg   writes the 8-bit brightness; ready out of reset. Write only while
//           no pixel is in flight; i_pix.ready stays low during the write
//           and while the corrected level settles.
// Timing:
//   Three register stages; a result is offered from the last of them.
//   One pixel per cycle sustained while the pipeline is not stalled and no
//   brightness write is settling; each lane stage holds one multiply and
//   takes a new pixel every cycle under the same conditions.
// Reset:
//   Brightness goes to 0 (all words 0x924924), the pipeline empties and
//   both input channels hold ready low.
// Stall:
//   When o_pulse.ready is low with a result held, the whole pipeline holds
//   and i_pix.ready drops; a held result stays stable until it is taken.
module rgb_level_to_ws2812_pulses (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rlwp_pix_if.sink     i_pix,
    rlwp_cfg_if.sink     i_cfg,
    rlwp_pulse_if.source o_pulse
);
    import rlwp_pkg::*;

    t_level     w_level;
    logic       w_en;
    logic       w_cfg_busy;
    logic [7:0] w_red_s;
    logic [7:0] w_green_s;
    logic [7:0] w_blue_s;
    logic       r_v1;
    logic       r_v2;
    logic       r_v3;

    assign w_en        = !r_v3 || o_pulse.ready;
    assign i_pix.ready = w_en && !w_cfg_busy && i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_pix.valid && !w_cfg_busy;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    rlwp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_level (w_level),
        .o_busy  (w_cfg_busy)
    );

    rlwp_lane u_lane_red (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_level  (w_level),
        .i_color  (i_pix.red_value),
        .o_scaled (w_red_s)
    );

    rlwp_lane u_lane_green (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_level  (w_level),
        .i_color  (i_pix.green_value),
        .o_scaled (w_green_s)
    );

    rlwp_lane u_lane_blue (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_level  (w_level),
        .i_color  (i_pix.blue_value),
        .o_scaled (w_blue_s)
    );

    rlwp_merge u_merge (
        .i_clk          (i_clk),
        .i_en           (w_en),
        .i_red          (w_red_s),
        .i_green        (w_green_s),
        .i_blue         (w_blue_s),
        .o_green_pulses (o_pulse.green_pulses),
        .o_red_pulses   (o_pulse.red_pulses),
        .o_blue_pulses  (o_pulse.blue_pulses)
    );

    assign o_pulse.valid = r_v3;

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix.valid && i_pix.ready |=> r_v1)
        else $error("accepted pixel did not enter stage 1");

    a_stage_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && w_en |=> r_v2)
        else $error("stage 1 pixel lost");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_v1) && $stable(r_v2))
        else $error("pipeline moved during stall");

    a_pulse_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pulse.valid |->
            ((o_pulse.green_pulses & 24'h924924) == 24'h924924) &&
            ((o_pulse.green_pulses & 24'h249249) == 24'h000000) &&
            ((o_pulse.red_pulses   & 24'h924924) == 24'h924924) &&
            ((o_pulse.red_pulses   & 24'h249249) == 24'h000000) &&
            ((o_pulse.blue_pulses  & 24'h924924) == 24'h924924) &&
            ((o_pulse.blue_pulses  & 24'h249249) == 24'h000000))
        else $error("malformed pulse word");

endmodule

FILE: rtl/rlwp_cfg.sv
// Brightness register and its quadratic correction (two multiply stages).
// Depends on rlwp_pkg and rlwp_cfg_if.
module rlwp_cfg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    rlwp_cfg_if.sink         i_cfg,
    output rlwp_pkg::t_level o_level,
    output logic             o_busy
);
    import rlwp_pkg::*;

    logic [7:0]  r_bright;
    logic [15:0] r_square;
    logic [7:0]  r_level;
    logic [1:0]  r_settle;
    logic [31:0] w_mul;

    assign i_cfg.ready = i_rst_n;
    assign w_mul       = r_square * RecipMul;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright <= '0;
            r_square <= '0;
            r_level  <= '0;
            r_settle <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_bright <= i_cfg.data;
            end
            r_square <= {8'd0, r_bright} * {8'd0, r_bright};
            r_level  <= w_mul[RecipShift +: 8];
            // level is two stages behind the register
            if (i_cfg.valid) begin
                r_settle <= 2'd2;
            end else if (r_settle != 2'd0) begin
                r_settle <= r_settle - 2'd1;
            end
        end
    end

    assign o_level.level     = r_level;
    assign o_level.bright_nz = (r_bright != 8'd0);
    assign o_busy            = i_cfg.valid || (r_settle != 2'd0);

endmodule

FILE: rtl/rlwp_lane.sv
// One color lane: scale by corrected level with rounding, then zero fixup.
// Two register stages. Depends on rlwp_pkg.
module rlwp_lane (
    input  logic             i_clk,
    input  logic             i_en,
    input  rlwp_pkg::t_level i_level,
    input  logic [7:0]       i_color,
    output logic [7:0]       o_scaled
);
    import rlwp_pkg::*;

    logic [15:0] r_prod;
    logic        r_nz;
    logic [7:0]  r_scaled;
    logic [31:0] w_mul;
    logic [7:0]  w_quot;

    assign w_mul  = r_prod * RecipMul;
    assign w_quot = w_mul[RecipShift +: 8];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod   <= ({8'd0, i_color} * {8'd0, i_level.level}) + {8'd0, LevelHalf};
            r_nz     <= (i_color != 8'd0) && i_level.bright_nz;
            r_scaled <= (w_quot == 8'd0 && r_nz) ? 8'd1 : w_quot;
        end
    end

    assign o_scaled = r_scaled;

endmodule

FILE: rtl/rlwp_merge.sv
// Merge stage: codes the three lane bytes into pulse words, GRB order register.
// Depends on rlwp_pkg.
module rlwp_merge (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    output logic [23:0] o_green_pulses,
    output logic [23:0] o_red_pulses,
    output logic [23:0] o_blue_pulses
);
    import rlwp_pkg::*;

    logic [23:0] r_green;
    logic [23:0] r_red;
    logic [23:0] r_blue;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_green <= encode_pulses(i_green);
            r_red   <= encode_pulses(i_red);
            r_blue  <= encode_pulses(i_blue);
        end
    end

    assign o_green_pulses = r_green;
    assign o_red_pulses   = r_red;
    assign o_blue_pulses  = r_blue;

endmodule

FILE: tb/tb_top.sv
// Testbench for rgb_level_to_ws2812_pulses: brightness scaling and pulse coding per pixel.
// Predicts each pixel's three pulse words and checks them in order against the output.
// Depends on rlwp_pkg, the rlwp channel interfaces and the rgb_level_to_ws2812_pulses RTL.
module tb_top;
    import rlwp_pkg::*;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [23:0] green;
        logic [23:0] red;
        logic [23:0] blue;
    } t_pulse_set;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    rlwp_pix_if   pix_ch();
    rlwp_cfg_if   cfg_ch();
    rlwp_pulse_if pulse_ch();

    rgb_level_to_ws2812_pulses u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch),
        .i_cfg   (cfg_ch),
        .o_pulse (pulse_ch)
    );

    t_pixel     pix_pending[$];
    t_pulse_set pulse_expect[$];
    logic [7:0] brightness_q = 8'd0;
    int         errors = 0;
    int         pix_xfer_cnt = 0;
    int         pix_seen_cnt = 0;
    int         pix_gap = 0;
    int         pulse_gap = 0;
    bit         pix_pace = 1'b1;
    bit         pulse_pace = 1'b1;
    bit         hold_req = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    function automatic logic [7:0] rand_color();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'($urandom_range(1, 3));
            3: return 8'd1 << $urandom_range(0, 7);
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // quadratic brightness, rounded scale, nonzero color never goes dark unless brightness is zero
    function automatic logic [7:0] scale_level(logic [7:0] color, logic [7:0] bright);
        int unsigned lvl;
        int unsigned c;
        int unsigned s;
        lvl = bright;
        lvl = (lvl * lvl) / 255;
        c = color;
        s = (c * lvl + LevelHalf) / 255;
        if (s == 0 && c != 0 && bright != 0) s = 1;
        return s[7:0];
    endfunction

    function automatic logic [23:0] pulse_code(logic [7:0] v);
        logic [23:0] w;
        w = '0;
        for (int k = 7; k >= 0; k--) begin
            w = {w[20:0], (v[k] ? PulseOne : PulseZero)};
        end
        return w;
    endfunction

    function automatic t_pulse_set predict_pulses(t_pixel p, logic [7:0] bright);
        t_pulse_set q;
        q.green = pulse_code(scale_level(p.green, bright));
        q.red   = pulse_code(scale_level(p.red, bright));
        q.blue  = pulse_code(scale_level(p.blue, bright));
        return q;
    endfunction

    // transfers on both input channels
    always @(posedge i_clk) begin
        if (i_rst_n && cfg_ch.valid && cfg_ch.ready) brightness_q <= cfg_ch.data;
        if (i_rst_n && pix_ch.valid && pix_ch.ready) begin
            pulse_expect.push_back(predict_pulses(
                t_pixel'{pix_ch.red_value, pix_ch.green_value, pix_ch.blue_value},
                brightness_q));
            void'(pix_pending.pop_front());
            pix_xfer_cnt <= pix_xfer_cnt + 1;
        end
    end

    // pixel driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pix_ch.valid <= 1'b0;
        end else if (!(pix_ch.valid && pix_seen_cnt == pix_xfer_cnt)) begin
            pix_seen_cnt <= pix_xfer_cnt;
            if (pix_gap > 0) begin
                pix_gap <= pix_gap - 1;
                pix_ch.valid <= 1'b0;
            end else if (pix_pending.size() > 0) begin
                pix_ch.valid       <= 1'b1;
                pix_ch.red_value   <= pix_pending[0].red;
                pix_ch.green_value <= pix_pending[0].green;
                pix_ch.blue_value  <= pix_pending[0].blue;
                pix_gap <= pix_pace ? pick_gap() : 0;
            end else begin
                pix_ch.valid <= 1'b0;
            end
        end
    end

    // result ready
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_req) begin
            pulse_ch.ready <= 1'b0;
        end else if (pulse_gap > 0) begin
            pulse_ch.ready <= 1'b0;
            pulse_gap <= pulse_gap - 1;
        end else begin
            pulse_ch.ready <= 1'b1;
            pulse_gap <= pulse_pace ? pick_gap() : 0;
        end
    end

    // long hold-off on the result side
    always begin
        wait (hold_req);
        repeat (300) @(posedge i_clk);
        hold_req = 1'b0;
    end

    always @(posedge i_clk) begin : pulse_monitor
        t_pulse_set want;
        if (i_rst_n && pulse_ch.valid && pulse_ch.ready) begin
            if (pulse_expect.size() == 0) begin
                errors++;
                $display("%0t: expected none actual g=%h r=%h b=%h", $time,
                         pulse_ch.green_pulses, pulse_ch.red_pulses, pulse_ch.blue_pulses);
            end else begin
                want = pulse_expect.pop_front();
                if (pulse_ch.green_pulses !== want.green) begin
                    errors++;
                    $display("%0t: green expected %h actual %h", $time,
                             want.green, pulse_ch.green_pulses);
                end
                if (pulse_ch.red_pulses !== want.red) begin
                    errors++;
                    $display("%0t: red expected %h actual %h", $time,
                             want.red, pulse_ch.red_pulses);
                end
                if (pulse_ch.blue_pulses !== want.blue) begin
                    errors++;
                    $display("%0t: blue expected %h actual %h", $time,
                             want.blue, pulse_ch.blue_pulses);
                end
            end
        end
    end

    task automatic add_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        pix_pending.push_back(t_pixel'{r, g, b});
    endtask

    task automatic drain();
        while (pix_pending.size() != 0 || pulse_expect.size() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic set_brightness(logic [7:0] b);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= b;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        // corrected level settles
        repeat (4) @(negedge i_clk);
    endtask

    initial begin
        logic [7:0] extremes[4];
        logic [7:0] b;
        extremes = '{8'd255, 8'd0, 8'd1, 8'd254};
        pix_ch.valid = 1'b0;
        pix_ch.red_value = 8'd0;
        pix_ch.green_value = 8'd0;
        pix_ch.blue_value = 8'd0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = 8'd0;
        pulse_ch.ready = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset brightness: all words dark
        add_pixel(8'd0, 8'd0, 8'd0);
        add_pixel(8'd255, 8'd255, 8'd255);
        add_pixel(8'd1, 8'd128, 8'd64);
        drain();

        set_brightness(8'd255);
        add_pixel(8'd0, 8'd0, 8'd0);
        add_pixel(8'd255, 8'd255, 8'd255);
        add_pixel(8'd1, 8'd2, 8'd4);
        add_pixel(8'd8, 8'd16, 8'd32);
        add_pixel(8'd64, 8'd128, 8'd170);
        add_pixel(8'd85, 8'd0, 8'd255);
        drain();

        // level floors to zero, nonzero colors forced to 1
        set_brightness(8'd1);
        add_pixel(8'd1, 8'd255, 8'd0);
        add_pixel(8'd128, 8'd1, 8'd2);
        drain();

        set_brightness(8'd16);
        add_pixel(8'd1, 8'd127, 8'd128);
        add_pixel(8'd255, 8'd2, 8'd3);
        drain();

        set_brightness(8'd128);
        add_pixel(8'd1, 8'd2, 8'd3);
        add_pixel(8'd0, 8'd255, 8'd4);
        drain();

        for (int ph = 0; ph < 11; ph++) begin
            b = (ph < 4) ? extremes[ph] : 8'($urandom_range(0, 255));
            set_brightness(b);
            @(negedge i_clk);
            pix_pace   = (ph % 4 != 3) && (ph != 5);
            pulse_pace = (ph % 3 != 2);
            if (ph == 5) begin
                @(posedge i_clk);
                hold_req = 1'b1;
            end
            for (int n = 0; n < 160; n++) begin
                add_pixel(rand_color(), rand_color(), rand_color());
            end
            drain();
        end

        repeat (10) @(negedge i_clk);
        if (errors == 0) begin
            $display("rgb_level_to_ws2812_pulses: match");
        end else begin
            $display("rgb_level_to_ws2812_pulses: mismatch");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("rgb_level_to_ws2812_pulses: mismatch");
        $finish;
    end

endmodule

FILE: rgb_level_to_ws2812_pulses.f
rtl/rlwp_pkg.sv
rtl/rlwp_ifs.sv
rtl/rlwp_cfg.sv
rtl/rlwp_lane.sv
rtl/rlwp_merge.sv
rtl/rgb_level_to_ws2812_pulses.sv
tb/tb_top.sv
